[sv/wsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and constants of the WAV stream to DAC sample block.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } wsd_phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_HEADER_OK = 2'd1,
        KIND_ERROR     = 2'd2
    } wsd_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_RIFF     = 4'd1,
        ERR_WAVE     = 4'd2,
        ERR_FMT      = 4'd3,
        ERR_NOT_PCM  = 4'd4,
        ERR_CHANNELS = 4'd5,
        ERR_BITS     = 4'd6,
        ERR_DATA_TAG = 4'd7,
        ERR_SIZE     = 4'd8,
        ERR_SHORT    = 4'd9
    } wsd_err_t;

    localparam int          APB_AW         = 3;
    localparam logic [0:0]  REG_GAIN       = 1'b0;
    localparam logic [7:0]  GAIN_RESET     = 8'd120;

    localparam logic [5:0]  HDR_LAST       = 6'd43;
    localparam logic [31:0] DATA_SIZE_BIAS = 32'd36;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] CH_MONO        = 16'd1;
    localparam logic [15:0] CH_STEREO      = 16'd2;
    localparam logic [15:0] BITS_8         = 16'd8;
    localparam logic [15:0] BITS_16        = 16'd16;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2^16
    localparam logic [16:0] RECIP_100      = 17'd83887;
    localparam int          RECIP_SHIFT    = 23;

    localparam logic signed [11:0] SAT_U8_MAX = 12'sd255;
    localparam logic signed [11:0] SAT_S8_MAX = 12'sd127;
    localparam logic signed [11:0] SAT_S8_MIN = -12'sd128;

    typedef struct packed {
        wsd_kind_t          kind;
        logic signed [17:0] product;
        logic               signed_mode;
        logic [31:0]        sample_rate;
        wsd_err_t           error_code;
        logic               last;
    } wsd_mid_t;

    function automatic logic [7:0] tag_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "R";
            4'd1:    c = "I";
            4'd2:    c = "F";
            4'd3:    c = "F";
            4'd4:    c = "W";
            4'd5:    c = "A";
            4'd6:    c = "V";
            4'd7:    c = "E";
            4'd8:    c = "f";
            4'd9:    c = "m";
            4'd10:   c = "t";
            4'd11:   c = " ";
            4'd12:   c = "d";
            4'd13:   c = "a";
            4'd14:   c = "t";
            4'd15:   c = "a";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

[sv/wsd_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ifs
// Valid/ready channels for file bytes in and result words out.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;

    modport source (output valid, data_byte, file_start, file_end, input ready);
    modport sink   (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface wsd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [8:0] sample;
    logic              signed_mode;
    logic [31:0]       sample_rate;
    logic [3:0]        error_code;
    logic              last;

    modport source (output valid, kind, sample, signed_mode, sample_rate, error_code, last,
                    input ready);
    modport sink   (input valid, kind, sample, signed_mode, sample_rate, error_code, last,
                    output ready);
endinterface

[sv/wsd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_cfg
// APB register slave holding the output gain in percent.
// ----------------------------------------------------------------------------
module wsd_cfg
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [7:0]        gain
);

    logic [7:0] gain_reg;
    logic       hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_AW-1:2] == REG_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            gain_reg <= pwdata[7:0];
        end
    end

    assign prdata = hit ? {24'd0, gain_reg} : 32'd0;
    assign gain   = gain_reg;

endmodule

[sv/wsd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Input register, header/data parse state and mono mix times gain.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wsd_in_if.sink     in_ch,
    input  logic [7:0] gain,
    output logic       mid_valid,
    output wsd_mid_t   mid,
    input  logic       mid_ready
);

    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic        a_start_reg;
    logic        a_end_reg;

    wsd_phase_t  phase_reg, phase_next, phase_cur;
    logic [5:0]  off_reg, off_next, off_cur;
    logic [31:0] riff_reg, riff_next, riff_cur;
    logic        stereo_reg, stereo_next, stereo_cur;
    logic        s16_reg, s16_next, s16_cur;
    logic [31:0] rate_reg, rate_next, rate_cur;
    logic [31:0] brem_reg, brem_next, brem_cur;
    logic [23:0] frame_reg, frame_next, frame_cur;
    logic [1:0]  pos_reg, pos_next, pos_cur;

    logic        mid_valid_reg;
    wsd_mid_t    mid_reg;
    wsd_mid_t    mid_next;
    logic        emit;

    logic        b_ready;
    logic        adv;

    wsd_err_t    herr;
    logic [5:0]  tag_off;
    logic [15:0] field16;
    logic [2:0]  fsize;
    logic [31:0] frame32;
    logic [31:0] brem_dec;
    logic        frame_done;

    logic [8:0]         mix8;
    logic signed [17:0] sum16;
    logic [17:0]        mag16;
    logic [8:0]         mq16;
    logic signed [9:0]  mono;
    logic signed [18:0] prod;

    assign b_ready     = !mid_valid_reg || mid_ready;
    assign adv         = a_valid_reg && b_ready;
    assign in_ch.ready = !a_valid_reg || b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            a_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            a_byte_reg  <= in_ch.data_byte;
            a_start_reg <= in_ch.file_start;
            a_end_reg   <= in_ch.file_end;
        end
    end

    // state as seen by this word, after a possible restart
    always_comb
    begin
        phase_cur  = a_start_reg ? PH_HEADER : phase_reg;
        off_cur    = a_start_reg ? 6'd0  : off_reg;
        riff_cur   = a_start_reg ? 32'd0 : riff_reg;
        stereo_cur = a_start_reg ? 1'b0  : stereo_reg;
        s16_cur    = a_start_reg ? 1'b0  : s16_reg;
        rate_cur   = a_start_reg ? 32'd0 : rate_reg;
        brem_cur   = a_start_reg ? 32'd0 : brem_reg;
        frame_cur  = a_start_reg ? 24'd0 : frame_reg;
        pos_cur    = a_start_reg ? 2'd0  : pos_reg;
    end

    always_comb
    begin
        fsize      = (stereo_cur && s16_cur) ? 3'd4 : ((stereo_cur || s16_cur) ? 3'd2 : 3'd1);
        frame32    = {8'd0, frame_cur} | ({24'd0, a_byte_reg} << {pos_cur, 3'b000});
        brem_dec   = brem_cur - 32'd1;
        frame_done = ({1'b0, pos_cur} + 3'd1) >= fsize;
        field16    = {a_byte_reg, frame_cur[7:0]};
    end

    // mono mix: 8-bit halves the sum, 16-bit divides the sum by 512 toward zero
    always_comb
    begin
        mix8  = ({1'b0, frame32[7:0]} + {1'b0, (stereo_cur ? frame32[15:8] : frame32[7:0])}) >> 1;
        sum16 = 18'(signed'(frame32[15:0]))
              + 18'(signed'(stereo_cur ? frame32[31:16] : frame32[15:0]));
        mag16 = sum16[17] ? 18'(-sum16) : 18'(sum16);
        mq16  = mag16[17:9];
        if (s16_cur)
        begin
            mono = sum16[17] ? -signed'({1'b0, mq16}) : signed'({1'b0, mq16});
        end
        else
        begin
            mono = signed'({1'b0, mix8});
        end
        prod = mono * signed'({1'b0, gain});
    end

    always_comb
    begin
        phase_next  = phase_cur;
        off_next    = off_cur;
        riff_next   = riff_cur;
        stereo_next = stereo_cur;
        s16_next    = s16_cur;
        rate_next   = rate_cur;
        brem_next   = brem_cur;
        frame_next  = frame_cur;
        pos_next    = pos_cur;
        herr        = ERR_NONE;
        tag_off     = 6'd0;
        emit        = 1'b0;
        mid_next    = '{kind: KIND_SAMPLE, product: 18'sd0, signed_mode: 1'b0,
                        sample_rate: 32'd0, error_code: ERR_NONE, last: 1'b0};

        case (phase_cur)
            PH_HEADER:
            begin
                if (off_cur inside {[6'd0:6'd3]})
                begin
                    if (a_byte_reg != tag_char(off_cur[3:0])) herr = ERR_RIFF;
                end
                else if (off_cur inside {[6'd8:6'd11]})
                begin
                    tag_off = off_cur - 6'd4;
                    if (a_byte_reg != tag_char(tag_off[3:0])) herr = ERR_WAVE;
                end
                else if (off_cur inside {[6'd12:6'd15]})
                begin
                    tag_off = off_cur - 6'd4;
                    if (a_byte_reg != tag_char(tag_off[3:0])) herr = ERR_FMT;
                end
                else if (off_cur inside {[6'd36:6'd39]})
                begin
                    tag_off = off_cur - 6'd24;
                    if (a_byte_reg != tag_char(tag_off[3:0])) herr = ERR_DATA_TAG;
                end
                else if (off_cur inside {[6'd4:6'd7]})
                begin
                    riff_next[{off_cur[1:0], 3'b000} +: 8] = a_byte_reg;
                end
                else if (off_cur inside {[6'd24:6'd27]})
                begin
                    rate_next[{off_cur[1:0], 3'b000} +: 8] = a_byte_reg;
                end
                else if (off_cur inside {[6'd40:6'd43]})
                begin
                    brem_next[{off_cur[1:0], 3'b000} +: 8] = a_byte_reg;
                    if (off_cur == HDR_LAST && brem_next != riff_cur - DATA_SIZE_BIAS)
                    begin
                        herr = ERR_SIZE;
                    end
                end
                else if (off_cur inside {6'd20, 6'd22, 6'd34})
                begin
                    frame_next = {16'd0, a_byte_reg};
                end
                else if (off_cur == 6'd21)
                begin
                    if (field16 != FMT_PCM) herr = ERR_NOT_PCM;
                end
                else if (off_cur == 6'd23)
                begin
                    if (field16 == CH_MONO)        stereo_next = 1'b0;
                    else if (field16 == CH_STEREO) stereo_next = 1'b1;
                    else                           herr = ERR_CHANNELS;
                end
                else if (off_cur == 6'd35)
                begin
                    if (field16 == BITS_8)       s16_next = 1'b0;
                    else if (field16 == BITS_16) s16_next = 1'b1;
                    else                         herr = ERR_BITS;
                end

                if (herr != ERR_NONE)
                begin
                    phase_next          = PH_IDLE;
                    emit                = 1'b1;
                    mid_next.kind       = KIND_ERROR;
                    mid_next.error_code = herr;
                end
                else if (off_cur == HDR_LAST)
                begin
                    phase_next           = (brem_next != 32'd0 && !a_end_reg) ? PH_DATA : PH_IDLE;
                    frame_next           = 24'd0;
                    pos_next             = 2'd0;
                    emit                 = 1'b1;
                    mid_next.kind        = KIND_HEADER_OK;
                    mid_next.signed_mode = s16_next;
                    mid_next.sample_rate = rate_next;
                end
                else
                begin
                    off_next = off_cur + 6'd1;
                    if (a_end_reg)
                    begin
                        phase_next          = PH_IDLE;
                        emit                = 1'b1;
                        mid_next.kind       = KIND_ERROR;
                        mid_next.error_code = ERR_SHORT;
                    end
                end
            end
            PH_DATA:
            begin
                brem_next = brem_dec;
                if (frame_done)
                begin
                    frame_next           = 24'd0;
                    pos_next             = 2'd0;
                    emit                 = 1'b1;
                    mid_next.kind        = KIND_SAMPLE;
                    mid_next.product     = prod[17:0];
                    mid_next.signed_mode = s16_cur;
                    mid_next.last        = a_end_reg || (brem_dec < {29'd0, fsize});
                end
                else
                begin
                    frame_next = frame32[23:0];
                    pos_next   = pos_cur + 2'd1;
                end
                if (brem_dec == 32'd0 || a_end_reg) phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            off_reg    <= 6'd0;
            riff_reg   <= 32'd0;
            stereo_reg <= 1'b0;
            s16_reg    <= 1'b0;
            rate_reg   <= 32'd0;
            brem_reg   <= 32'd0;
            frame_reg  <= 24'd0;
            pos_reg    <= 2'd0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            riff_reg   <= riff_next;
            stereo_reg <= stereo_next;
            s16_reg    <= s16_next;
            rate_reg   <= rate_next;
            brem_reg   <= brem_next;
            frame_reg  <= frame_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            mid_valid_reg <= adv && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

[sv/wsd_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_scaler
// Divide the gained sample by 100, saturate, and hold the result word.
// ----------------------------------------------------------------------------
module wsd_scaler
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mid_valid,
    input  wsd_mid_t   mid,
    output logic       mid_ready,
    wsd_out_if.source  out_ch
);

    logic              out_valid_reg;
    wsd_kind_t         kind_reg;
    logic signed [8:0] sample_reg, sample_next;
    logic              signed_mode_reg;
    logic [31:0]       rate_reg;
    wsd_err_t          err_reg;
    logic              last_reg;

    logic [16:0]        mag;
    logic [33:0]        scaled;
    logic [10:0]        quot;
    logic signed [11:0] val;

    assign mid_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        mag    = mid.product[17] ? 17'(-mid.product) : mid.product[16:0];
        scaled = mag * RECIP_100;
        quot   = scaled[RECIP_SHIFT +: 11];
        val    = mid.product[17] ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
        if (mid.signed_mode)
        begin
            if (val > SAT_S8_MAX)      sample_next = 9'(SAT_S8_MAX);
            else if (val < SAT_S8_MIN) sample_next = 9'(SAT_S8_MIN);
            else                       sample_next = val[8:0];
        end
        else
        begin
            if (val > SAT_U8_MAX) sample_next = 9'(SAT_U8_MAX);
            else                  sample_next = val[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_ready && mid_valid)
        begin
            kind_reg        <= mid.kind;
            sample_reg      <= sample_next;
            signed_mode_reg <= mid.signed_mode;
            rate_reg        <= mid.sample_rate;
            err_reg         <= mid.error_code;
            last_reg        <= mid.last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.sample      = sample_reg;
    assign out_ch.signed_mode = signed_mode_reg;
    assign out_ch.sample_rate = rate_reg;
    assign out_ch.error_code  = err_reg;
    assign out_ch.last        = last_reg;

endmodule

[sv/wav_stream_to_dac_samples.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_to_dac_samples
// Parse a WAV byte stream and turn its PCM frames into gained DAC samples.
// ----------------------------------------------------------------------------
// Feed the file one byte per word, flagging the first byte with file_start and
// the last delivered byte with file_end. The 44-byte header yields one word:
// header accepted (with sample rate and signed mode) or an error code. Each
// complete data frame yields one sample word, mixed to mono, scaled by
// gain_percent/100 and saturated; last marks the final sample. A byte word is
// taken every cycle when the output is drained, and its result word passes
// through the input register, the parse stage holding the gain multiply and
// the output stage holding the divide by 100. The gain register sits at APB
// address 0 and resets to 120.
module wav_stream_to_dac_samples
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wsd_in_if.sink            in_ch,
    wsd_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] gain;
    logic       mid_valid;
    logic       mid_ready;
    wsd_mid_t   mid;

    wsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain)
    );

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .gain      (gain),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_ready (mid_ready)
    );

    wsd_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_ready (mid_ready),
        .out_ch    (out_ch)
    );

endmodule

[sv/wsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on result words of the WAV stream block.
// ----------------------------------------------------------------------------
module wsd_checker
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        kind,
    input  logic signed [8:0] sample,
    input  logic              signed_mode,
    input  logic [31:0]       sample_rate,
    input  logic [3:0]        error_code,
    input  logic              last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(kind))
        else $error("result word changed while stalled");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |->
            error_code != ERR_NONE && sample == 9'sd0 && !signed_mode
            && sample_rate == 32'd0 && !last)
        else $error("malformed error word");

    a_ok_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADER_OK |->
            error_code == ERR_NONE && sample == 9'sd0 && !last)
        else $error("malformed header word");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SAMPLE |->
            error_code == ERR_NONE && sample_rate == 32'd0
            && (signed_mode || !sample[8])
            && (!signed_mode || sample[8] == sample[7]))
        else $error("sample out of range");

endmodule

bind wav_stream_to_dac_samples wsd_checker u_wsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .sample      (out_ch.sample),
    .signed_mode (out_ch.signed_mode),
    .sample_rate (out_ch.sample_rate),
    .error_code  (out_ch.error_code),
    .last        (out_ch.last)
);
